// ===== rtl/bce_pkg.sv =====
// shared constants, codes and types of the bezier curve evaluator
package bce_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int COORD_W = 32;
  localparam int IDX_W   = 6;
  localparam int T_W     = 17;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;
  localparam logic [COORD_W-1:0] SIGN_FLIP   = 32'h8000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_DRAIN,
    SEQ_FINAL,
    SEQ_FWAIT
  } seq_state_t;

  typedef struct packed {
    logic rd_en;
    logic rd_src_ctrl;
  } lane_ctl_t;

endpackage

// ===== rtl/bce_if.sv =====
// handshake channels of the bezier curve evaluator
interface bce_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [bce_pkg::IDX_W-1:0]         point_index;
  logic signed [bce_pkg::COORD_W-1:0] coord_x;
  logic signed [bce_pkg::COORD_W-1:0] coord_y;
  logic signed [bce_pkg::COORD_W-1:0] coord_z;
  logic [bce_pkg::T_W-1:0]           t_param;

  modport source (output valid, opcode, point_index, coord_x, coord_y, coord_z, t_param,
                  input ready);
  modport sink   (input valid, opcode, point_index, coord_x, coord_y, coord_z, t_param,
                  output ready);
endinterface

interface bce_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bce_pkg::COORD_W-1:0] curve_x;
  logic signed [bce_pkg::COORD_W-1:0] curve_y;
  logic signed [bce_pkg::COORD_W-1:0] curve_z;

  modport source (output valid, curve_x, curve_y, curve_z, input ready);
  modport sink   (input valid, curve_x, curve_y, curve_z, output ready);
endinterface

// ===== rtl/bce_lane.sv =====
// one coordinate lane: point store, work store and interpolation pipeline
module bce_lane #(
  parameter int MAX_POINTS  = bce_pkg::MAX_POINTS_DEF,
  parameter int T_FRAC_BITS = bce_pkg::T_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [$clog2(MAX_POINTS)-1:0]    wr_addr,
  input  logic [bce_pkg::COORD_W-1:0]      wr_data,
  input  bce_pkg::lane_ctl_t               ctl,
  input  logic [$clog2(MAX_POINTS)-1:0]    rd_addr,
  input  logic [T_FRAC_BITS:0]             coef_a,
  input  logic [T_FRAC_BITS:0]             coef_b,
  output logic [bce_pkg::COORD_W-1:0]      rd_data
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int TW = T_FRAC_BITS + 1;
  localparam int PW = bce_pkg::COORD_W + TW;
  localparam logic [PW:0] HALF = (PW+1)'(1) << (T_FRAC_BITS - 1);

  logic [bce_pkg::COORD_W-1:0] ctrl_mem [MAX_POINTS];
  logic [bce_pkg::COORD_W-1:0] work_mem [MAX_POINTS];

  logic [bce_pkg::COORD_W-1:0] rd_ctrl_r, rd_work_r, prev_r;
  logic                        d1_valid_r, d1_src_r;
  logic [AW-1:0]               d1_addr_r;
  logic                        p_valid_r;
  logic [AW-1:0]               p_addr_r;
  logic [PW-1:0]               pa_r, pb_r;
  logic [PW:0]                 sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ctrl_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_ctrl_r <= ctrl_mem[rd_addr];
      rd_work_r <= work_mem[rd_addr];
    end
  end

  assign rd_data = d1_src_r ? rd_ctrl_r : rd_work_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_valid_r <= 1'b0;
      d1_src_r   <= 1'b0;
      p_valid_r  <= 1'b0;
    end else begin
      d1_valid_r <= ctl.rd_en;
      if (ctl.rd_en) begin
        d1_src_r <= ctl.rd_src_ctrl;
      end
      p_valid_r <= d1_valid_r && (d1_addr_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      d1_addr_r <= rd_addr;
    end
    if (d1_valid_r) begin
      prev_r   <= rd_data;
      pa_r     <= PW'(prev_r) * PW'(coef_b);
      pb_r     <= PW'(rd_data) * PW'(coef_a);
      p_addr_r <= d1_addr_r - 1'b1;
    end
  end

  // rounded convex combination stays inside the 32-bit operand range
  assign sum = {1'b0, pa_r} + {1'b0, pb_r} + HALF;

  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      work_mem[p_addr_r] <= bce_pkg::COORD_W'(sum >> T_FRAC_BITS);
    end
  end

endmodule

// ===== rtl/bce_seq.sv =====
// level and index sequencer shared by the three lanes
module bce_seq #(
  parameter int MAX_POINTS  = bce_pkg::MAX_POINTS_DEF,
  parameter int T_FRAC_BITS = bce_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          eval_start,
  input  logic [bce_pkg::T_W-1:0]       t_param,
  input  logic [bce_pkg::COUNT_W-1:0]   point_count,
  input  logic                          out_free,
  output logic                          idle,
  output bce_pkg::lane_ctl_t            ctl,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output logic [T_FRAC_BITS:0]          coef_a,
  output logic [T_FRAC_BITS:0]          coef_b,
  output logic                          out_load,
  output logic                          out_zero
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = T_FRAC_BITS + 1;
  localparam logic [TW-1:0] ONE = TW'(1) << T_FRAC_BITS;

  bce_pkg::seq_state_t state_r, state_nxt;
  logic [AW-1:0] level_r, level_nxt, top_r, top_nxt, addr_r, addr_nxt;
  logic [1:0]    drain_r, drain_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic          zero_r, zero_nxt, single_r, single_nxt;
  logic [CW-1:0] cnt;
  logic [TW-1:0] t_sat;

  assign cnt   = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign t_sat = (32'(t_param) > (32'(1) << T_FRAC_BITS)) ? ONE : TW'(t_param);

  assign coef_a = t_r;
  assign coef_b = ONE - t_r;
  assign out_zero = zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bce_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r  <= level_nxt;
    top_r    <= top_nxt;
    addr_r   <= addr_nxt;
    drain_r  <= drain_nxt;
    t_r      <= t_nxt;
    zero_r   <= zero_nxt;
    single_r <= single_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    level_nxt       = level_r;
    top_nxt         = top_r;
    addr_nxt        = addr_r;
    drain_nxt       = drain_r;
    t_nxt           = t_r;
    zero_nxt        = zero_r;
    single_nxt      = single_r;
    idle            = 1'b0;
    ctl.rd_en       = 1'b0;
    ctl.rd_src_ctrl = 1'b0;
    rd_addr         = addr_r;
    out_load        = 1'b0;
    case (state_r)
      bce_pkg::SEQ_IDLE: begin
        idle = 1'b1;
        if (eval_start) begin
          t_nxt      = t_sat;
          zero_nxt   = (cnt == '0);
          single_nxt = (cnt == CW'(1));
          level_nxt  = AW'(cnt - 1'b1);
          top_nxt    = AW'(cnt - 1'b1);
          addr_nxt   = '0;
          if (cnt == '0) begin
            state_nxt = bce_pkg::SEQ_FWAIT;
          end else if (cnt == CW'(1)) begin
            state_nxt = bce_pkg::SEQ_FINAL;
          end else begin
            state_nxt = bce_pkg::SEQ_READ;
          end
        end
      end
      bce_pkg::SEQ_READ: begin
        // the first level reads the point store, later ones the work store
        ctl.rd_en       = 1'b1;
        ctl.rd_src_ctrl = (level_r == top_r);
        addr_nxt        = addr_r + 1'b1;
        if (addr_r == level_r) begin
          drain_nxt = '0;
          state_nxt = bce_pkg::SEQ_DRAIN;
        end
      end
      bce_pkg::SEQ_DRAIN: begin
        // let the last write of the level land before the next one reads
        drain_nxt = drain_r + 1'b1;
        if (drain_r == 2'd2) begin
          addr_nxt = '0;
          if (level_r == AW'(1)) begin
            state_nxt = bce_pkg::SEQ_FINAL;
          end else begin
            level_nxt = level_r - 1'b1;
            state_nxt = bce_pkg::SEQ_READ;
          end
        end
      end
      bce_pkg::SEQ_FINAL: begin
        ctl.rd_en       = 1'b1;
        ctl.rd_src_ctrl = single_r;
        rd_addr         = '0;
        state_nxt       = bce_pkg::SEQ_FWAIT;
      end
      bce_pkg::SEQ_FWAIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = bce_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = bce_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bezier_curve_evaluator_unit.sv =====
// top level of the bezier curve evaluator: lanes, sequencer and result merge
// Usage:
// in_ch carries load items (opcode load: write point coord_x/y/z at point_index)
// and evaluate items (opcode eval: curve point at t_param). out_ch returns one
// curve point per evaluate item, none per load. cfg_we/cfg_wdata set point_count.
// A load leaves the sequencer idle, so in_ch stays ready afterwards.
// An evaluate item with n points runs de Casteljau level by level: each level of
// k interpolations takes k+1 store reads followed by a pipeline drain, and all
// reads go through the single read port of each lane's work store. x, y and z
// run in three lanes side by side. in_ch is not ready during an evaluation.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, a further evaluation holds its finished point until
// the output register frees up.
// Reset clears the sequencer, the output valid and sets point_count to 1;
// stored points are undefined until loaded.
module bezier_curve_evaluator_unit #(
  parameter int MAX_POINTS  = bce_pkg::MAX_POINTS_DEF,
  parameter int T_FRAC_BITS = bce_pkg::T_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bce_in_if.sink                       in_ch,
  bce_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [bce_pkg::COUNT_W-1:0]  cfg_wdata
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int TW = T_FRAC_BITS + 1;

  logic [bce_pkg::COUNT_W-1:0] count_r;
  logic                        idle, in_xfer, wr_en, out_load, out_zero;
  bce_pkg::lane_ctl_t          ctl;
  logic [AW-1:0]               rd_addr;
  logic [TW-1:0]               coef_a, coef_b;
  logic [bce_pkg::COORD_W-1:0] rd_x, rd_y, rd_z;
  logic                        out_valid_r;
  logic [bce_pkg::COORD_W-1:0] out_x_r, out_y_r, out_z_r;

  assign in_ch.ready = idle;
  assign in_xfer     = in_ch.valid && idle;
  assign wr_en       = in_xfer && (in_ch.opcode == bce_pkg::OP_LOAD)
                       && (32'(in_ch.point_index) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= bce_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  bce_seq #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .eval_start  (in_xfer && (in_ch.opcode == bce_pkg::OP_EVAL)),
    .t_param     (in_ch.t_param),
    .point_count (count_r),
    .out_free    (!out_valid_r || out_ch.ready),
    .idle        (idle),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .out_load    (out_load),
    .out_zero    (out_zero)
  );

  // points are stored in offset binary so the lanes interpolate unsigned
  bce_lane #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS)) u_lane_x (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(AW'(in_ch.point_index)),
    .wr_data(in_ch.coord_x ^ bce_pkg::SIGN_FLIP), .ctl(ctl), .rd_addr(rd_addr),
    .coef_a(coef_a), .coef_b(coef_b), .rd_data(rd_x)
  );

  bce_lane #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS)) u_lane_y (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(AW'(in_ch.point_index)),
    .wr_data(in_ch.coord_y ^ bce_pkg::SIGN_FLIP), .ctl(ctl), .rd_addr(rd_addr),
    .coef_a(coef_a), .coef_b(coef_b), .rd_data(rd_y)
  );

  bce_lane #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS)) u_lane_z (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(AW'(in_ch.point_index)),
    .wr_data(in_ch.coord_z ^ bce_pkg::SIGN_FLIP), .ctl(ctl), .rd_addr(rd_addr),
    .coef_a(coef_a), .coef_b(coef_b), .rd_data(rd_z)
  );

  // merge the lane results into one output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r <= out_zero ? '0 : (rd_x ^ bce_pkg::SIGN_FLIP);
      out_y_r <= out_zero ? '0 : (rd_y ^ bce_pkg::SIGN_FLIP);
      out_z_r <= out_zero ? '0 : (rd_z ^ bce_pkg::SIGN_FLIP);
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.curve_x = out_x_r;
  assign out_ch.curve_y = out_y_r;
  assign out_ch.curve_z = out_z_r;

endmodule

// ===== rtl/bce_checker.sv =====
// port level checks of the bezier curve evaluator and their binding
module bce_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_opcode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bce_pkg::COORD_W-1:0] out_x
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("outputs not cleared by reset");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == bce_pkg::OP_EVAL) |=> !in_ready)
    else $error("input still ready during an evaluation");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == bce_pkg::OP_LOAD) |=> in_ready)
    else $error("load transfer blocked the input");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x))
    else $error("stalled result dropped or changed");

endmodule

bind bezier_curve_evaluator_unit bce_checker u_bce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.curve_x)
);
